@@ sv/estm_pkg.sv @@
// ----------------------------------------------------------------------------
// estm_pkg
// Shared constants and helpers for the Euler scale transform matrix unit.
// ----------------------------------------------------------------------------
package estm_pkg;

	// Default widths of the angle ports and of the sine and cosine fraction.
	localparam int ANGLE_BITS_DEF     = 16;
	localparam int TRIG_FRAC_BITS_DEF = 14;

	// Pi over two in Q30.
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

	// Pipeline depth of the sine and cosine unit (two stages per series term),
	// and of the whole unit.
	localparam int SC_STAGES  = 17;
	localparam int ALL_STAGES = SC_STAGES + 3;

	// Quadrant codes of the top two bits of a turn.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	// Shift right by n with rounding half away from zero.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int n);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
		r   = (mag + (64'd1 << (n - 1))) >> n;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	// Number of trailing zero bits of a positive constant.
	function automatic int low_zeros(input int d);
		int n;
		int v;
		n = 0;
		v = d;
		while (v != 0 && (v & 1) == 0) begin
			v = v >> 1;
			n++;
		end
		return n;
	endfunction

endpackage

@@ sv/estm_sincos.sv @@
// ----------------------------------------------------------------------------
// estm_sincos
// Pipelined sine and cosine of a binary angle: Taylor series in Q30, one
// correction term every two stages, rounded to Q1.TRIG_FRAC_BITS.
// ----------------------------------------------------------------------------
module estm_sincos import estm_pkg::*; #(
	parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ANGLE_BITS-1:0]            angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

	localparam int TW = TRIG_FRAC_BITS + 2;

	logic [31:0] turn;
	logic [60:0] x_prod;
	logic [30:0] x_s1;
	logic [1:0]  quad_s1;
	logic [61:0] x2_prod;

	logic [30:0]        ts_q [0:7];
	logic [30:0]        tc_q [0:7];
	logic signed [32:0] sa_q [0:7];
	logic signed [32:0] ca_q [0:7];
	logic [31:0]        x2_q [0:7];
	logic [1:0]         qd_q [0:7];

	// Stage one: the angle as radians in Q30 and its quadrant.
	assign turn   = {angle, {(32 - ANGLE_BITS){1'b0}}};
	assign x_prod = turn[29:0] * PI_HALF_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_prod[60:30];
			quad_s1 <= turn[31:30];
		end
	end

	// Stage two: the square and the first terms of both series.
	assign x2_prod = x_s1 * x_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_q[0] <= x2_prod[61:30];
			ts_q[0] <= x_s1;
			sa_q[0] <= $signed({2'b00, x_s1});
			tc_q[0] <= 31'd1 << 30;
			ca_q[0] <= $signed(33'd1 << 30);
			qd_q[0] <= quad_s1;
		end
	end

	// One correction term of each series per pair of stages. The divisor is
	// split into a power of two, taken by a shift, and an odd part, taken by
	// an exact reciprocal multiplication.
	for (genvar k = 1; k <= 7; k++) begin : g_term
		localparam int DivS = (2 * k) * (2 * k + 1);
		localparam int DivC = (2 * k - 1) * (2 * k);
		localparam int ShS  = low_zeros(DivS);
		localparam int ShC  = low_zeros(DivC);
		localparam int LogS = $clog2(DivS >> ShS);
		localparam int LogC = $clog2(DivC >> ShC);
		localparam logic [32:0] MagS =
			33'(((64'd1 << (32 + LogS)) / 64'(DivS >> ShS)) + 64'd1);
		localparam logic [32:0] MagC =
			33'(((64'd1 << (32 + LogC)) / 64'(DivC >> ShC)) + 64'd1);
		logic [62:0]        ps;
		logic [62:0]        pc;
		logic [64:0]        qs_prod;
		logic [64:0]        qc_prod;
		logic [30:0]        ns;
		logic [30:0]        nc;
		logic [31:0]        qs_q;
		logic [31:0]        qc_q;
		logic signed [32:0] sam_q;
		logic signed [32:0] cam_q;
		logic [31:0]        x2m_q;
		logic [1:0]         qdm_q;

		// First half: product with x squared and the power-of-two part.
		assign ps = ts_q[k-1] * x2_q[k-1];
		assign pc = tc_q[k-1] * x2_q[k-1];

		always_ff @(posedge clk) begin
			if (en) begin
				qs_q  <= 32'(ps[62:30] >> ShS);
				qc_q  <= 32'(pc[62:30] >> ShC);
				sam_q <= sa_q[k-1];
				cam_q <= ca_q[k-1];
				x2m_q <= x2_q[k-1];
				qdm_q <= qd_q[k-1];
			end
		end

		// Second half: the odd part of the divisor and the running sums.
		assign qs_prod = qs_q * MagS;
		assign qc_prod = qc_q * MagC;
		assign ns      = 31'(qs_prod >> (32 + LogS));
		assign nc      = 31'(qc_prod >> (32 + LogC));

		always_ff @(posedge clk) begin
			if (en) begin
				ts_q[k] <= ns;
				tc_q[k] <= nc;
				sa_q[k] <= (k % 2 == 1) ? sam_q - $signed({2'b00, ns})
				                        : sam_q + $signed({2'b00, ns});
				ca_q[k] <= (k % 2 == 1) ? cam_q - $signed({2'b00, nc})
				                        : cam_q + $signed({2'b00, nc});
				x2_q[k] <= x2m_q;
				qd_q[k] <= qdm_q;
			end
		end
	end

	// Final stage: clamp, round to the trig format and unfold the quadrant.
	function automatic logic signed [TW-1:0] to_trig(input logic signed [32:0] v);
		logic [30:0] c;
		logic [31:0] u;
		if (v < 0)
			c = 31'd0;
		else if (v > $signed(33'd1 << 30))
			c = 31'd1 << 30;
		else
			c = v[30:0];
		u = ({1'b0, c} + (32'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		if (u > (32'd1 << TRIG_FRAC_BITS))
			u = 32'd1 << TRIG_FRAC_BITS;
		return $signed(u[TW-1:0]);
	endfunction

	logic signed [TW-1:0] sv;
	logic signed [TW-1:0] cv;

	assign sv = to_trig(sa_q[7]);
	assign cv = to_trig(ca_q[7]);

	always_ff @(posedge clk) begin
		if (en) begin
			case (qd_q[7])
				QUAD_0: begin
					sin_val <= sv;
					cos_val <= cv;
				end
				QUAD_1: begin
					sin_val <= cv;
					cos_val <= -sv;
				end
				QUAD_2: begin
					sin_val <= -sv;
					cos_val <= -cv;
				end
				default: begin
					sin_val <= -cv;
					cos_val <= sv;
				end
			endcase
		end
	end

endmodule

@@ sv/euler_scale_transform_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// euler_scale_transform_matrix_unit
// Scaled Y-X-Z Tait-Bryan rotation with translation, as the upper 3x4 part
// of a 4x4 model transform, in fixed point.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  input   | in_valid, in_ready  | pos_x/y/z, scale_x/y/z, angle_x/y/z
//  output  | out_valid, out_ready| m00..m22, tx, ty, tz
//
// One transaction enters per cycle while the pipeline advances; each result
// passes through seventeen stages of sine and cosine and three matrix stages.
// The whole pipeline advances together and freezes while a result waits.
// Reset clears only the valid bits; the data path holds no reset.
// ----------------------------------------------------------------------------
module euler_scale_transform_matrix_unit import estm_pkg::*; #(
	parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic signed [15:0]    scale_x,
	input  logic signed [15:0]    scale_y,
	input  logic signed [15:0]    scale_z,
	input  logic [ANGLE_BITS-1:0] angle_x,
	input  logic [ANGLE_BITS-1:0] angle_y,
	input  logic [ANGLE_BITS-1:0] angle_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    m00,
	output logic signed [15:0]    m01,
	output logic signed [15:0]    m02,
	output logic signed [15:0]    m10,
	output logic signed [15:0]    m11,
	output logic signed [15:0]    m12,
	output logic signed [15:0]    m20,
	output logic signed [15:0]    m21,
	output logic signed [15:0]    m22,
	output logic signed [31:0]    tx,
	output logic signed [31:0]    ty,
	output logic signed [31:0]    tz
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int SW = TW + 1;

	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [SW-1:0] sum_t;

	logic en;
	logic [ALL_STAGES-1:0] vld_q;

	// Whole pipeline moves unless a finished result is held.
	assign en        = !vld_q[ALL_STAGES-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[ALL_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ALL_STAGES-2:0], in_valid};
		end
	end

	// Side data carried alongside the arithmetic.
	logic signed [31:0] px_q [0:ALL_STAGES-1];
	logic signed [31:0] py_q [0:ALL_STAGES-1];
	logic signed [31:0] pz_q [0:ALL_STAGES-1];
	logic signed [15:0] sx_q [0:ALL_STAGES-2];
	logic signed [15:0] sy_q [0:ALL_STAGES-2];
	logic signed [15:0] sz_q [0:ALL_STAGES-2];

	always_ff @(posedge clk) begin
		if (en) begin
			px_q[0] <= pos_x;
			py_q[0] <= pos_y;
			pz_q[0] <= pos_z;
			sx_q[0] <= scale_x;
			sy_q[0] <= scale_y;
			sz_q[0] <= scale_z;
			for (int i = 1; i < ALL_STAGES; i++) begin
				px_q[i] <= px_q[i-1];
				py_q[i] <= py_q[i-1];
				pz_q[i] <= pz_q[i-1];
			end
			for (int i = 1; i < ALL_STAGES - 1; i++) begin
				sx_q[i] <= sx_q[i-1];
				sy_q[i] <= sy_q[i-1];
				sz_q[i] <= sz_q[i-1];
			end
		end
	end

	assign tx = px_q[ALL_STAGES-1];
	assign ty = py_q[ALL_STAGES-1];
	assign tz = pz_q[ALL_STAGES-1];

	// Sine and cosine of each axis: 1 = Y, 2 = X, 3 = Z.
	trig_t s1, c1, s2, c2, s3, c3;

	estm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_y (
		.clk(clk), .en(en), .angle(angle_y), .sin_val(s1), .cos_val(c1));
	estm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_x (
		.clk(clk), .en(en), .angle(angle_x), .sin_val(s2), .cos_val(c2));
	estm_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sc_z (
		.clk(clk), .en(en), .angle(angle_z), .sin_val(s3), .cos_val(c3));

	function automatic trig_t mulr(input trig_t a, input trig_t b);
		logic signed [2*TW-1:0] p;
		p = a * b;
		return TW'(rnd_shift(64'(p), TRIG_FRAC_BITS));
	endfunction

	function automatic logic signed [15:0] scaled(input logic signed [15:0] s, input sum_t t);
		logic signed [SW+15:0] p;
		logic signed [63:0]    r;
		p = s * t;
		r = rnd_shift(64'(p), TRIG_FRAC_BITS);
		if (r > 64'sd32767)
			return 16'sh7fff;
		else if (r < -64'sd32768)
			return 16'sh8000;
		else
			return 16'(r);
	endfunction

	// Matrix stage one: pair products.
	trig_t c1c3_s1, c3s1_s1, c1s3_s1, s1s3_s1, s1s2_s1, c1s2_s1;
	trig_t c2s3_s1, c2c3_s1, c2s1_s1, c1c2_s1, s2_s1, s3_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c1c3_s1 <= mulr(c1, c3);
			c3s1_s1 <= mulr(c3, s1);
			c1s3_s1 <= mulr(c1, s3);
			s1s3_s1 <= mulr(s1, s3);
			s1s2_s1 <= mulr(s1, s2);
			c1s2_s1 <= mulr(c1, s2);
			c2s3_s1 <= mulr(c2, s3);
			c2c3_s1 <= mulr(c2, c3);
			c2s1_s1 <= mulr(c2, s1);
			c1c2_s1 <= mulr(c1, c2);
			s2_s1   <= s2;
			s3_s1   <= s3;
		end
	end

	// Matrix stage two: triple products and sums.
	sum_t t00_s2, t01_s2, t02_s2, t10_s2, t11_s2, t12_s2, t20_s2, t21_s2, t22_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t00_s2 <= SW'(c1c3_s1) + SW'(mulr(s1s2_s1, s3_s1));
			t01_s2 <= SW'(c2s3_s1);
			t02_s2 <= SW'(mulr(c1s2_s1, s3_s1)) - SW'(c3s1_s1);
			t10_s2 <= SW'(mulr(c3s1_s1, s2_s1)) - SW'(c1s3_s1);
			t11_s2 <= SW'(c2c3_s1);
			t12_s2 <= SW'(mulr(c1c3_s1, s2_s1)) + SW'(s1s3_s1);
			t20_s2 <= SW'(c2s1_s1);
			t21_s2 <= -SW'(s2_s1);
			t22_s2 <= SW'(c1c2_s1);
		end
	end

	// Matrix stage three: column scale, rounding and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			m00 <= scaled(sx_q[ALL_STAGES-2], t00_s2);
			m01 <= scaled(sx_q[ALL_STAGES-2], t01_s2);
			m02 <= scaled(sx_q[ALL_STAGES-2], t02_s2);
			m10 <= scaled(sy_q[ALL_STAGES-2], t10_s2);
			m11 <= scaled(sy_q[ALL_STAGES-2], t11_s2);
			m12 <= scaled(sy_q[ALL_STAGES-2], t12_s2);
			m20 <= scaled(sz_q[ALL_STAGES-2], t20_s2);
			m21 <= scaled(sz_q[ALL_STAGES-2], t21_s2);
			m22 <= scaled(sz_q[ALL_STAGES-2], t22_s2);
		end
	end

	// A held result keeps the whole pipeline frozen.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	// An accepted transaction always enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction lost at entry");

	// A delivered result leaves room for a new transaction.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input blocked while output drains");

endmodule
